/* rtl/core/rss_pkg.sv */
package rss_pkg;

  localparam int MAX_APPS   = 64;
  localparam int NUM_PROCS  = 3;

  localparam int ID_W       = $clog2(MAX_APPS);
  localparam int CNT_W      = $clog2(MAX_APPS + 1);
  localparam int PROC_W     = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int APP_W      = 7;
  localparam int PIDX_W     = 3;
  localparam int MBOX_W     = 3;
  localparam int TICK_W     = 64;
  localparam int POLL_W     = 8;
  localparam int PREEMPT_W  = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT_MIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT = 1'd1;

  localparam logic [PREEMPT_W-1:0] PREEMPT_MIN_RST = 16'd10;
  localparam logic [POLL_W-1:0]    STUCK_LIMIT_RST = 8'd5;
  localparam logic [POLL_W-1:0]    POLL_MAX        = 8'hFF;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_CREATE = 3'd1,
    KIND_RUN    = 3'd2,
    KIND_SCHED  = 3'd3,
    KIND_CLEAN  = 3'd4,
    KIND_PAUSE  = 3'd5,
    KIND_READY  = 3'd6,
    KIND_RESET  = 3'd7
  } rss_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_PROC  = 3'd1,
    ST_NO_APP    = 3'd2,
    ST_APP_STATE = 3'd3,
    ST_NO_ID     = 3'd4
  } rss_status_e;

  typedef enum logic [1:0] {
    SEND_NONE   = 2'd0,
    SEND_EXEC   = 2'd1,
    SEND_SWITCH = 2'd2
  } rss_send_e;

  typedef enum logic [1:0] {
    PH_RESETTING = 2'd0,
    PH_IDLE      = 2'd1,
    PH_RESERVED  = 2'd2,
    PH_RUNNING   = 2'd3
  } rss_phase_e;

  typedef struct packed {
    rss_kind_e          kind;
    logic [APP_W-1:0]   app_id;
    logic [PIDX_W-1:0]  proc_index;
    logic [MBOX_W-1:0]  mailbox_free;
  } rss_in_t;

  typedef struct packed {
    rss_status_e        status;
    logic [APP_W-1:0]   new_app_id;
    rss_send_e          send_kind;
    logic [PIDX_W-1:0]  send_proc;
    logic [APP_W-1:0]   send_app;
    logic               stuck;
  } rss_out_t;

  typedef struct packed {
    logic [PREEMPT_W-1:0] preempt_min_ticks;
    logic [POLL_W-1:0]    stuck_limit;
  } rss_cfg_t;

  typedef struct packed {
    logic             push;
    logic [APP_W-1:0] push_id;
    logic             pop;
  } rss_fifo_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [APP_W-1:0] head_id;
  } rss_fifo_stat_t;

endpackage

/* rtl/core/rss_ready_fifo.sv */
module rss_ready_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rss_pkg::rss_fifo_req_t  req_i,
  output rss_pkg::rss_fifo_stat_t stat_o
);
  import rss_pkg::*;

  logic [ID_W-1:0]  mem [MAX_APPS];
  logic [ID_W-1:0]  head_q, head_d;
  logic [ID_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [ID_W-1:0]  rd_q;
  logic             push_ok;
  logic [APP_W-1:0] push_m1;
  logic [ID_W-1:0]  wr_data;

  function automatic logic [ID_W-1:0] ptr_next(logic [ID_W-1:0] p);
    return (p == ID_W'(MAX_APPS - 1)) ? '0 : ID_W'(p + ID_W'(1));
  endfunction

  always_comb begin
    push_ok = req_i.push && (count_q != CNT_W'(MAX_APPS));
    push_m1 = APP_W'(req_i.push_id - APP_W'(1));
    wr_data = push_m1[ID_W-1:0];
    head_d  = req_i.pop ? ptr_next(head_q) : head_q;
    tail_d  = push_ok ? ptr_next(tail_q) : tail_q;
    count_d = CNT_W'(count_q + CNT_W'(push_ok) - CNT_W'(req_i.pop));
  end

  assign stat_o.count   = count_q;
  assign stat_o.head_id = APP_W'(APP_W'(rd_q) + APP_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // prefetch the next head, forwarding a write to the same entry
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail_q] <= wr_data;
    end
    if (push_ok && (tail_q == head_d)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem[head_d];
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_APPS))
    else $error("ready queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.pop |-> (count_q != '0) || req_i.push)
    else $error("pop from empty ready queue");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.push || req_i.pop) |=> $stable(count_q) && $stable(head_q) && $stable(tail_q))
    else $error("ready queue moved without request");
`endif

endmodule

/* rtl/core/rss_sched_core.sv */
module rss_sched_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  rss_pkg::rss_in_t        item_i,
  input  rss_pkg::rss_cfg_t       cfg_i,
  output rss_pkg::rss_fifo_req_t  fifo_req_o,
  input  rss_pkg::rss_fifo_stat_t fifo_stat_i,
  output rss_pkg::rss_out_t       res_o
);
  import rss_pkg::*;

  rss_phase_e        phase_q   [NUM_PROCS];
  rss_phase_e        phase_d   [NUM_PROCS];
  logic [APP_W-1:0]  app_q     [NUM_PROCS];
  logic [APP_W-1:0]  app_d     [NUM_PROCS];
  logic [TICK_W-1:0] elapsed_q [NUM_PROCS];
  logic [TICK_W-1:0] elapsed_d [NUM_PROCS];
  logic [MAX_APPS-1:0] in_use_q, in_use_d;
  logic [MAX_APPS-1:0] started_q, started_d;
  logic              await_valid_q, await_valid_d;
  logic [PROC_W-1:0] await_proc_q, await_proc_d;
  logic [POLL_W-1:0] polls_q, polls_d;

  rss_out_t          res;
  rss_fifo_req_t     freq;
  logic [PROC_W-1:0] pidx;
  logic              pidx_ok;
  logic [APP_W-1:0]  sel_app;
  logic [APP_W-1:0]  sel_m1;
  logic              proc_run_ok;
  logic [APP_W-1:0]  aid_m1;
  logic              aid_ok;
  logic              free_found;
  logic [ID_W-1:0]   free_idx;
  logic              idle_found;
  logic [PROC_W-1:0] idle_idx;
  logic              cand_found;
  logic [PROC_W-1:0] cand_idx;
  logic [TICK_W-1:0] best;
  logic [MBOX_W+NUM_PROCS-1:0] mb_ext;
  logic [NUM_PROCS-1:0] mfree;
  logic              do_sched;
  logic              pick_ok;
  logic [PROC_W-1:0] pick;
  logic [POLL_W-1:0] polls_inc;
  logic [APP_W-1:0]  head_id;
  logic [APP_W-1:0]  head_m1;
  logic [PROC_W-1:0] send_pidx;

  assign pidx    = item_i.proc_index[PROC_W-1:0];
  assign pidx_ok = item_i.proc_index < PIDX_W'(NUM_PROCS);
  assign sel_app = pidx_ok ? app_q[pidx] : '0;
  assign sel_m1  = APP_W'(sel_app - APP_W'(1));
  assign proc_run_ok = pidx_ok && (phase_q[pidx] == PH_RUNNING) && (sel_app != '0) &&
                       (sel_app <= APP_W'(MAX_APPS));
  assign aid_m1  = APP_W'(item_i.app_id - APP_W'(1));
  assign aid_ok  = (item_i.app_id != '0) && (item_i.app_id <= APP_W'(MAX_APPS)) &&
                   in_use_q[aid_m1[ID_W-1:0]];
  // empty queue: the app pushed by this run request is also the head
  assign head_id = (fifo_stat_i.count == '0) ? item_i.app_id : fifo_stat_i.head_id;
  assign head_m1 = APP_W'(head_id - APP_W'(1));
  assign mb_ext  = {NUM_PROCS'(0), item_i.mailbox_free};

  // lowest free id, lowest idle processor, longest-running preemptable processor
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_APPS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = ID_W'(i);
      end
    end
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int i = NUM_PROCS - 1; i >= 0; i--) begin
      if (phase_q[i] == PH_IDLE) begin
        idle_found = 1'b1;
        idle_idx   = PROC_W'(i);
      end
    end
    cand_found = 1'b0;
    cand_idx   = '0;
    best       = '0;
    for (int i = 0; i < NUM_PROCS; i++) begin
      mfree[i] = mb_ext[i];
      if ((phase_q[i] == PH_RUNNING) &&
          (elapsed_q[i] >= TICK_W'(cfg_i.preempt_min_ticks)) && (elapsed_q[i] > best)) begin
        cand_found = 1'b1;
        cand_idx   = PROC_W'(i);
        best       = elapsed_q[i];
      end
    end
  end

  always_comb begin
    phase_d       = phase_q;
    app_d         = app_q;
    elapsed_d     = elapsed_q;
    in_use_d      = in_use_q;
    started_d     = started_q;
    await_valid_d = await_valid_q;
    await_proc_d  = await_proc_q;
    polls_d       = polls_q;
    res           = '0;
    res.status    = ST_OK;
    res.send_kind = SEND_NONE;
    freq          = '0;
    do_sched      = 1'b0;
    pick_ok       = 1'b0;
    pick          = '0;
    polls_inc     = (polls_q == POLL_MAX) ? polls_q : POLL_W'(polls_q + POLL_W'(1));

    case (item_i.kind)
      KIND_TICK: begin
        for (int i = 0; i < NUM_PROCS; i++) begin
          elapsed_d[i] = TICK_W'(elapsed_q[i] + TICK_W'(1));
        end
      end
      KIND_CREATE: begin
        if (free_found) begin
          in_use_d[free_idx]  = 1'b1;
          started_d[free_idx] = 1'b0;
          res.new_app_id      = APP_W'(APP_W'(free_idx) + APP_W'(1));
        end else begin
          res.status = ST_NO_ID;
        end
      end
      KIND_RUN: begin
        if (!aid_ok) begin
          res.status = ST_NO_APP;
        end else if (started_q[aid_m1[ID_W-1:0]]) begin
          res.status = ST_APP_STATE;
        end else begin
          started_d[aid_m1[ID_W-1:0]] = 1'b1;
          freq.push    = 1'b1;
          freq.push_id = item_i.app_id;
          do_sched     = 1'b1;
        end
      end
      KIND_SCHED: begin
        do_sched = 1'b1;
      end
      KIND_CLEAN, KIND_PAUSE: begin
        if (!proc_run_ok) begin
          res.status = ST_BAD_PROC;
        end else begin
          phase_d[pidx] = PH_RESETTING;
          if (item_i.kind == KIND_CLEAN) begin
            app_d[pidx] = '0;
            in_use_d[sel_m1[ID_W-1:0]]  = 1'b0;
            started_d[sel_m1[ID_W-1:0]] = 1'b0;
          end else begin
            // requeue the paused app
            started_d[sel_m1[ID_W-1:0]] = 1'b1;
            freq.push    = 1'b1;
            freq.push_id = sel_app;
          end
        end
      end
      KIND_READY: begin
        if (!pidx_ok || (phase_q[pidx] != PH_RESETTING)) begin
          res.status = ST_BAD_PROC;
        end else begin
          phase_d[pidx] = PH_IDLE;
        end
      end
      KIND_RESET: begin
        if (!pidx_ok || (phase_q[pidx] != PH_IDLE)) begin
          res.status = ST_BAD_PROC;
        end else begin
          phase_d[pidx] = PH_RESETTING;
        end
      end
      default: begin
      end
    endcase

    if (do_sched && ((fifo_stat_i.count != '0) || freq.push)) begin
      if (await_valid_q) begin
        if (phase_q[await_proc_q] != PH_IDLE) begin
          polls_d   = polls_inc;
          res.stuck = polls_inc > cfg_i.stuck_limit;
        end else begin
          await_valid_d = 1'b0;
          pick_ok       = 1'b1;
          pick          = await_proc_q;
        end
      end else if (idle_found) begin
        pick_ok = 1'b1;
        pick    = idle_idx;
      end else if (cand_found) begin
        if (mfree[cand_idx]) begin
          res.send_kind = SEND_SWITCH;
          res.send_proc = PIDX_W'(cand_idx);
        end
        await_valid_d = 1'b1;
        await_proc_d  = cand_idx;
        polls_d       = '0;
      end

      if (pick_ok) begin
        freq.pop = 1'b1;
        if (!mfree[pick]) begin
          // mailbox busy: drop the popped app, free the processor
          phase_d[pick] = PH_IDLE;
        end else begin
          started_d[head_m1[ID_W-1:0]] = 1'b1;
          elapsed_d[pick] = '0;
          app_d[pick]     = head_id;
          phase_d[pick]   = PH_RUNNING;
          res.send_kind   = SEND_EXEC;
          res.send_proc   = PIDX_W'(pick);
          res.send_app    = head_id;
        end
      end
    end
  end

  assign res_o           = res;
  assign fifo_req_o.push    = freq.push && step_i;
  assign fifo_req_o.push_id = freq.push_id;
  assign fifo_req_o.pop     = freq.pop && step_i;
  assign send_pidx       = res.send_proc[PROC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PROCS; i++) begin
        phase_q[i]   <= PH_RESETTING;
        app_q[i]     <= '0;
        elapsed_q[i] <= '0;
      end
      in_use_q      <= '0;
      started_q     <= '0;
      await_valid_q <= 1'b0;
      await_proc_q  <= '0;
      polls_q       <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      app_q         <= app_d;
      elapsed_q     <= elapsed_d;
      in_use_q      <= in_use_d;
      started_q     <= started_d;
      await_valid_q <= await_valid_d;
      await_proc_q  <= await_proc_d;
      polls_q       <= polls_d;
    end
  end

`ifndef ASSERT_OFF
  a_exec_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res.send_kind == SEND_EXEC) |=> phase_q[$past(send_pidx)] == PH_RUNNING)
    else $error("execute sent but processor not running");

  a_switch_awaits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res.send_kind == SEND_SWITCH) |=>
      await_valid_q && (await_proc_q == $past(send_pidx)))
    else $error("switch request sent without awaiting that processor");

  a_stuck_awaiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.stuck |-> await_valid_q)
    else $error("stuck flagged while not awaiting");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(in_use_q) && $stable(await_valid_q) && $stable(polls_q))
    else $error("scheduler state changed without a step");
`endif

endmodule

/* rtl/core/runtime_slot_scheduler.sv */
// Runtime slot scheduler.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one event word per
// cycle: tick, create, run app, schedule, clean up, pause, runtime ready or
// runtime reset, with the processor mailbox-free mask. Every event yields
// exactly one result word on the output channel (out_valid_o/out_ready_i/
// out_data_o): status, any new app id, and the message to send, if any.
// An accepted word waits in the input register; its result is shown on
// out_data_o from the result register. Throughput: one word per cycle while
// results are taken; all decisions for an event (id priority encode, queue
// head, idle/preempt choice over the processors) settle between the input
// register and the result register. When the receiver stalls, the result
// register holds, the input register fills, and in_ready_o drops until a
// result is taken. Reset clears the id map, the ready queue pointers, the
// await tracker and all processor phases to resetting; the block can take
// words from the first edge after reset. Configuration (preempt_min_ticks
// at index 0, stuck_limit at index 1) resets to 10 and 5; the user must
// write it through cfg_we_i while the block is idle; this is not enforced.
module runtime_slot_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rss_pkg::rss_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rss_pkg::rss_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [rss_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rss_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import rss_pkg::*;

  logic           in_valid_q;
  rss_in_t        in_data_q;
  logic           out_valid_q;
  rss_out_t       out_data_q;
  rss_cfg_t       cfg_q;
  logic           step;
  rss_out_t       res;
  rss_fifo_req_t  fifo_req;
  rss_fifo_stat_t fifo_stat;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preempt_min_ticks <= PREEMPT_MIN_RST;
      cfg_q.stuck_limit       <= STUCK_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREEMPT_MIN: cfg_q.preempt_min_ticks <= cfg_data_i[PREEMPT_W-1:0];
        CFG_STUCK_LIMIT: cfg_q.stuck_limit       <= cfg_data_i[POLL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rss_sched_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_data_q),
    .cfg_i       (cfg_q),
    .fifo_req_o  (fifo_req),
    .fifo_stat_i (fifo_stat),
    .res_o       (res)
  );

  rss_ready_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fifo_req),
    .stat_o (fifo_stat)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
